// ===== sv/keypad_code_lock_controller_macros.svh =====
// Assertion macros shared by the lock controller modules.
// Each macro expects clk_i and rst_ni in scope.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

`define CKLC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cklc assertion failed");

`define CKLC_ASSERT_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("cklc forbidden condition seen");

`else

`define CKLC_ASSERT(name, prop)

`define CKLC_ASSERT_NEVER(name, prop)

`endif

`endif

// ===== sv/cklc_pkg.sv =====
package cklc_pkg;

  localparam int unsigned KEY_W   = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned EVENT_W = 4;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned FAIL_W  = 4;
  localparam int unsigned OUTCNT_W = 3;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST = 4'd4;
  localparam logic [DIGIT_W-1:0] CODE_DIGIT_RST = 4'd1;

  localparam logic [KEY_W-1:0] SCAN_NONE = 5'd0;
  localparam logic [KEY_W-1:0] SCAN_1    = 5'd1;
  localparam logic [KEY_W-1:0] SCAN_2    = 5'd2;
  localparam logic [KEY_W-1:0] SCAN_3    = 5'd3;
  localparam logic [KEY_W-1:0] SCAN_4    = 5'd5;
  localparam logic [KEY_W-1:0] SCAN_5    = 5'd6;
  localparam logic [KEY_W-1:0] SCAN_6    = 5'd7;
  localparam logic [KEY_W-1:0] SCAN_7    = 5'd9;
  localparam logic [KEY_W-1:0] SCAN_8    = 5'd10;
  localparam logic [KEY_W-1:0] SCAN_9    = 5'd11;
  localparam logic [KEY_W-1:0] SCAN_STAR = 5'd13;
  localparam logic [KEY_W-1:0] SCAN_0    = 5'd14;
  localparam logic [KEY_W-1:0] SCAN_HASH = 5'd15;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_STAR  = 2'd2,
    KIND_HASH  = 2'd3
  } kind_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_UNLOCK = 2'd1,
    MODE_CHECK  = 2'd2,
    MODE_NEWPW  = 2'd3
  } mode_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 4'd0,
    EV_DIGIT     = 4'd1,
    EV_DISCARD   = 4'd2,
    EV_UNLOCK    = 4'd3,
    EV_FAIL      = 4'd4,
    EV_WARN      = 4'd5,
    EV_CHECKED   = 4'd6,
    EV_CHECKFAIL = 4'd7,
    EV_CHANGED   = 4'd8,
    EV_ENTERED   = 4'd9
  } event_e;

  typedef struct packed {
    kind_e              kind;
    logic [DIGIT_W-1:0] digit;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_rd_t;

  function automatic item_t map_key(input logic [KEY_W-1:0] key);
    item_t it;
    it.kind  = KIND_DIGIT;
    it.digit = '0;
    unique case (key)
      SCAN_1:    it.digit = 4'd1;
      SCAN_2:    it.digit = 4'd2;
      SCAN_3:    it.digit = 4'd3;
      SCAN_4:    it.digit = 4'd4;
      SCAN_5:    it.digit = 4'd5;
      SCAN_6:    it.digit = 4'd6;
      SCAN_7:    it.digit = 4'd7;
      SCAN_8:    it.digit = 4'd8;
      SCAN_9:    it.digit = 4'd9;
      SCAN_0:    it.digit = 4'd0;
      SCAN_STAR: it.kind  = KIND_STAR;
      SCAN_HASH: it.kind  = KIND_HASH;
      default:   it.kind  = KIND_NONE;
    endcase
    return it;
  endfunction

endpackage

// ===== sv/cklc_front.sv =====
module cklc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cklc_pkg::KEY_W-1:0]  key_code_i,
  input  logic                        q_full_i,
  output cklc_pkg::q_wr_t             q_wr_o
);
  import cklc_pkg::*;

  logic [KEY_W-1:0] prev_q;
  logic             accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // a held key acts once: repeats become empty items
  always_comb begin
    q_wr_o.push = accept;
    if (key_code_i != prev_q) begin
      q_wr_o.item = map_key(key_code_i);
    end else begin
      q_wr_o.item.kind  = KIND_NONE;
      q_wr_o.item.digit = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= SCAN_NONE;
    end else if (accept) begin
      prev_q <= key_code_i;
    end
  end

endmodule

// ===== sv/cklc_queue.sv =====
`include "keypad_code_lock_controller_macros.svh"

module cklc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cklc_pkg::q_wr_t wr_i,
  output logic            full_o,
  output cklc_pkg::q_rd_t rd_o,
  input  logic            pop_i
);
  import cklc_pkg::*;

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.item  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wptr_q] <= wr_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i.push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      unique case ({wr_i.push, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `CKLC_ASSERT(a_no_overflow, wr_i.push |-> !full_o)
  `CKLC_ASSERT(a_no_underflow, pop_i |-> rd_o.valid)
  `CKLC_ASSERT_NEVER(a_cnt_range, cnt_q > QCNT_W'(QDEPTH))

endmodule

// ===== sv/cklc_back.sv =====
`include "keypad_code_lock_controller_macros.svh"

module cklc_back #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cklc_pkg::FAIL_W-1:0]    cfg_fail_limit_i,
  input  cklc_pkg::q_rd_t                rd_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cklc_pkg::EVENT_W-1:0]   event_res_o,
  output logic [cklc_pkg::MODE_W-1:0]    mode_now_o,
  output logic [cklc_pkg::OUTCNT_W-1:0]  digit_count_o,
  output logic [cklc_pkg::DIGIT_W-1:0]   digit_value_o,
  output logic [cklc_pkg::FAIL_W-1:0]    failures_o
);
  import cklc_pkg::*;

  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int unsigned IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  logic [FAIL_W-1:0]  limit_q;
  mode_e              mode_q, mode_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FAIL_W-1:0]  fail_q, fail_d;
  logic [DIGIT_W-1:0] digits_q [CODE_DIGITS];
  logic [DIGIT_W-1:0] code_q [CODE_DIGITS];
  logic               out_valid_q;
  event_e             ev_q, ev_d;
  logic [DIGIT_W-1:0] dval_q, dval_d;
  logic               wr_digit, wr_code, match, full;
  logic [CNT_W+OUTCNT_W-1:0] cnt_ext;
  item_t              it;

  assign it    = rd_i.item;
  assign pop_o = rd_i.valid && (!out_valid_q || !out_stall_i);
  assign full  = (cnt_q >= CNT_W'(CODE_DIGITS));

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if ((CNT_W'(i) < cnt_q) && (digits_q[i] != code_q[i])) begin
        match = 1'b0;
      end
    end
  end

  // event, buffer and counter updates for the item at the queue head
  always_comb begin
    ev_d     = EV_NONE;
    dval_d   = '0;
    cnt_d    = cnt_q;
    fail_d   = fail_q;
    wr_digit = 1'b0;
    wr_code  = 1'b0;
    if (mode_q == MODE_IDLE) begin
      if (it.kind == KIND_STAR || it.kind == KIND_HASH) begin
        ev_d  = EV_ENTERED;
        cnt_d = '0;
      end
    end else if (it.kind == KIND_DIGIT) begin
      if (full) begin
        ev_d  = EV_DISCARD;
        cnt_d = '0;
      end else begin
        ev_d     = EV_DIGIT;
        dval_d   = it.digit;
        wr_digit = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end
    end else if (cnt_q != '0) begin
      priority if (mode_q == MODE_UNLOCK && it.kind == KIND_STAR) begin
        cnt_d = '0;
        if (match) begin
          ev_d = EV_UNLOCK;
        end else if (fail_q >= limit_q) begin
          ev_d   = EV_WARN;
          fail_d = '0;
        end else begin
          ev_d   = EV_FAIL;
          fail_d = fail_q + 1'b1;
        end
      end else if (mode_q == MODE_CHECK && it.kind == KIND_HASH) begin
        cnt_d = '0;
        ev_d  = match ? EV_CHECKED : EV_CHECKFAIL;
      end else if (mode_q == MODE_NEWPW && it.kind == KIND_HASH) begin
        cnt_d   = '0;
        ev_d    = EV_CHANGED;
        wr_code = 1'b1;
      end else begin
        ev_d = EV_NONE;
      end
    end
  end

  always_comb begin
    unique case (ev_d)
      EV_ENTERED: mode_d = (it.kind == KIND_STAR) ? MODE_UNLOCK : MODE_CHECK;
      EV_UNLOCK, EV_FAIL, EV_WARN, EV_CHANGED: mode_d = MODE_IDLE;
      EV_CHECKED: mode_d = MODE_NEWPW;
      default: mode_d = mode_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= FAIL_LIMIT_RST;
      mode_q      <= MODE_IDLE;
      cnt_q       <= '0;
      fail_q      <= '0;
      out_valid_q <= 1'b0;
      ev_q        <= EV_NONE;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_fail_limit_i;
      end
      if (pop_o) begin
        mode_q      <= mode_d;
        cnt_q       <= cnt_d;
        fail_q      <= fail_d;
        ev_q        <= ev_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dval_q <= dval_d;
    end
    if (pop_o && wr_digit) begin
      digits_q[cnt_q[IDX_W-1:0]] <= it.digit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        code_q[i] <= CODE_DIGIT_RST;
      end
    end else if (pop_o && wr_code) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (CNT_W'(i) < cnt_q) begin
          code_q[i] <= digits_q[i];
        end
      end
    end
  end

  assign cnt_ext       = {{OUTCNT_W{1'b0}}, cnt_q};
  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign mode_now_o    = mode_q;
  assign digit_count_o = cnt_ext[OUTCNT_W-1:0];
  assign digit_value_o = dval_q;
  assign failures_o    = fail_q;

  `CKLC_ASSERT_NEVER(a_cnt_bound, cnt_q > CNT_W'(CODE_DIGITS))
  `CKLC_ASSERT(a_idle_empty, mode_q == MODE_IDLE |-> cnt_q == '0)
  `CKLC_ASSERT(a_checked_newpw, (out_valid_q && ev_q == EV_CHECKED) |-> mode_q == MODE_NEWPW)

endmodule

// ===== sv/keypad_code_lock_controller.sv =====
// Keypad code lock controller. Each accepted item is one raw scan code; each
// item yields exactly one result (event, mode, digits held, digit, failures).
// One item is accepted per cycle unless the input is stalled. The front stage
// filters repeated codes and classifies the key, a two-entry queue decouples
// it from the back stage, and the back stage updates the lock state and the
// compare against the stored code of CODE_DIGITS digits. A result passes
// through the queue and the back stage's output register before it shows on
// the outputs; input stall rises only when the queue is full, which happens
// only while the output side is stalled. fail_limit is written through
// fail_limit_we_i/fail_limit_i and resets to 4; each stored digit resets to 1.
module keypad_code_lock_controller #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fail_limit_we_i,
  input  logic [cklc_pkg::FAIL_W-1:0]    fail_limit_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cklc_pkg::KEY_W-1:0]     key_code_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cklc_pkg::EVENT_W-1:0]   event_res_o,
  output logic [cklc_pkg::MODE_W-1:0]    mode_now_o,
  output logic [cklc_pkg::OUTCNT_W-1:0]  digit_count_o,
  output logic [cklc_pkg::DIGIT_W-1:0]   digit_value_o,
  output logic [cklc_pkg::FAIL_W-1:0]    failures_o
);
  import cklc_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  cklc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .key_code_i (key_code_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr)
  );

  cklc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .rd_o   (q_rd),
    .pop_i  (q_pop)
  );

  cklc_back #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (fail_limit_we_i),
    .cfg_fail_limit_i (fail_limit_i),
    .rd_i             (q_rd),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_o      (event_res_o),
    .mode_now_o       (mode_now_o),
    .digit_count_o    (digit_count_o),
    .digit_value_o    (digit_value_o),
    .failures_o       (failures_o)
  );

endmodule

// ===== bench/lock_result_checker.sv =====
`timescale 1ns / 1ps

module lock_result_checker #(
  parameter int unsigned DIGITS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fail_limit_we_i,
  input  logic [cklc_pkg::FAIL_W-1:0]     fail_limit_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [cklc_pkg::KEY_W-1:0]      key_code_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [cklc_pkg::EVENT_W-1:0]    event_res_i,
  input  logic [cklc_pkg::MODE_W-1:0]     mode_now_i,
  input  logic [cklc_pkg::OUTCNT_W-1:0]   digit_count_i,
  input  logic [cklc_pkg::DIGIT_W-1:0]    digit_value_i,
  input  logic [cklc_pkg::FAIL_W-1:0]     failures_i,
  output int                              err_count_o,
  output int                              pending_o,
  output int                              checked_o,
  output logic [9:0]                      events_seen_o,
  output cklc_pkg::mode_e                 mode_o,
  output int                              held_o,
  output logic [DIGITS*cklc_pkg::DIGIT_W-1:0] code_o
);
  import cklc_pkg::*;

  typedef struct packed {
    event_e               ev;
    mode_e                mode;
    logic [OUTCNT_W-1:0]  held;
    logic [DIGIT_W-1:0]   digit;
    logic [FAIL_W-1:0]    fails;
  } lock_result_t;

  mode_e              lock_mode;
  logic [KEY_W-1:0]   last_key;
  logic [DIGIT_W-1:0] entry_buf [DIGITS];
  int                 held;
  logic [DIGIT_W-1:0] code [DIGITS];
  logic [FAIL_W-1:0]  fail_cnt;
  logic [FAIL_W-1:0]  fail_lim;
  lock_result_t       expected_results [$];

  assign mode_o = lock_mode;
  assign held_o = held;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      code_o[i*DIGIT_W +: DIGIT_W] = code[i];
    end
  end

  function automatic lock_result_t predict_lock_result(input logic [KEY_W-1:0] key);
    lock_result_t       r;
    kind_e              kind;
    logic [DIGIT_W-1:0] dig;
    logic [KEY_W-1:0]   digit_keys [10];
    bit                 hit;
    digit_keys = '{SCAN_0, SCAN_1, SCAN_2, SCAN_3, SCAN_4,
                   SCAN_5, SCAN_6, SCAN_7, SCAN_8, SCAN_9};
    r.ev = EV_NONE;
    r.digit = '0;
    if (key != last_key) begin
      last_key = key;
      kind = KIND_NONE;
      dig = '0;
      for (int d = 0; d < 10; d++) begin
        if (key == digit_keys[d]) begin
          kind = KIND_DIGIT;
          dig = DIGIT_W'(d);
        end
      end
      if (key == SCAN_STAR) kind = KIND_STAR;
      if (key == SCAN_HASH) kind = KIND_HASH;

      if (lock_mode == MODE_IDLE) begin
        if (kind == KIND_STAR) begin
          lock_mode = MODE_UNLOCK;
          held = 0;
          r.ev = EV_ENTERED;
        end else if (kind == KIND_HASH) begin
          lock_mode = MODE_CHECK;
          held = 0;
          r.ev = EV_ENTERED;
        end
      end else if (kind == KIND_DIGIT) begin
        if (held >= DIGITS) begin
          held = 0;
          r.ev = EV_DISCARD;
        end else begin
          entry_buf[held] = dig;
          held++;
          r.ev = EV_DIGIT;
          r.digit = dig;
        end
      end else if (held != 0) begin
        hit = 1'b1;
        for (int i = 0; i < held; i++) begin
          if (entry_buf[i] != code[i]) hit = 1'b0;
        end
        case (lock_mode)
          MODE_UNLOCK: if (kind == KIND_STAR) begin
            if (hit) begin
              r.ev = EV_UNLOCK;
            end else if (fail_cnt >= fail_lim) begin
              fail_cnt = '0;
              r.ev = EV_WARN;
            end else begin
              fail_cnt = fail_cnt + 1'b1;
              r.ev = EV_FAIL;
            end
            lock_mode = MODE_IDLE;
            held = 0;
          end
          MODE_CHECK: if (kind == KIND_HASH) begin
            if (hit) begin
              lock_mode = MODE_NEWPW;
              r.ev = EV_CHECKED;
            end else begin
              r.ev = EV_CHECKFAIL;
            end
            held = 0;
          end
          MODE_NEWPW: if (kind == KIND_HASH) begin
            for (int i = 0; i < held; i++) code[i] = entry_buf[i];
            lock_mode = MODE_IDLE;
            r.ev = EV_CHANGED;
            held = 0;
          end
          default: ;
        endcase
      end
    end
    r.mode = lock_mode;
    r.held = OUTCNT_W'(held);
    r.fails = fail_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lock_result_t want;
    if (!rst_ni) begin
      lock_mode = MODE_IDLE;
      last_key = SCAN_NONE;
      held = 0;
      fail_cnt = '0;
      fail_lim = FAIL_LIMIT_RST;
      for (int i = 0; i < DIGITS; i++) begin
        entry_buf[i] = '0;
        code[i] = CODE_DIGIT_RST;
      end
      expected_results.delete();
      err_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      events_seen_o = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (event_res_i <= 4'd9) events_seen_o[event_res_i] = 1'b1;
        if (expected_results.size() == 0) begin
          err_count_o++;
          $display("%0t: result with nothing expected, expected none, actual event %0d",
                   $time, event_res_i);
        end else begin
          want = expected_results.pop_front();
          check_field("event", want.ev, event_res_i);
          check_field("mode", want.mode, mode_now_i);
          check_field("digit count", want.held, digit_count_i);
          check_field("digit value", want.digit, digit_value_i);
          check_field("wrong-try count", want.fails, failures_i);
        end
      end
      if (fail_limit_we_i) fail_lim = fail_limit_i;
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_lock_result(key_code_i));
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cklc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_SLACK    = 6;

  logic                clk_i;
  logic                rst_ni;
  logic                fail_limit_we_i;
  logic [FAIL_W-1:0]   fail_limit_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [KEY_W-1:0]    key_code_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [EVENT_W-1:0]  event_res_o;
  logic [MODE_W-1:0]   mode_now_o;
  logic [OUTCNT_W-1:0] digit_count_o;
  logic [DIGIT_W-1:0]  digit_value_o;
  logic [FAIL_W-1:0]   failures_o;

  int                  errors;
  int                  pending;
  int                  checked;
  logic [9:0]          events_seen;
  mode_e               mode_now;
  int                  held_now;
  logic [4*DIGIT_W-1:0] code_now;

  int                  keys_sent;
  int                  send_style;
  int                  take_style;
  int                  settings_used;
  bit                  hold_long;

  keypad_code_lock_controller DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fail_limit_we_i (fail_limit_we_i),
    .fail_limit_i    (fail_limit_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .key_code_i      (key_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_o     (event_res_o),
    .mode_now_o      (mode_now_o),
    .digit_count_o   (digit_count_o),
    .digit_value_o   (digit_value_o),
    .failures_o      (failures_o)
  );

  lock_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fail_limit_we_i (fail_limit_we_i),
    .fail_limit_i    (fail_limit_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .key_code_i      (key_code_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_i     (event_res_o),
    .mode_now_i      (mode_now_o),
    .digit_count_i   (digit_count_o),
    .digit_value_i   (digit_value_o),
    .failures_i      (failures_o),
    .err_count_o     (errors),
    .pending_o       (pending),
    .checked_o       (checked),
    .events_seen_o   (events_seen),
    .mode_o          (mode_now),
    .held_o          (held_now),
    .code_o          (code_now)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_wait(input int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] digit_scan(input int d);
    logic [KEY_W-1:0] keys [10];
    keys = '{SCAN_0, SCAN_1, SCAN_2, SCAN_3, SCAN_4,
             SCAN_5, SCAN_6, SCAN_7, SCAN_8, SCAN_9};
    return keys[d];
  endfunction

  task automatic send_key(input logic [KEY_W-1:0] key);
    int gap;
    gap = draw_wait(send_style);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    key_code_i = key;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    keys_sent++;
  endtask

  task automatic press(input logic [KEY_W-1:0] key);
    send_key(key);
    send_key(SCAN_NONE);
  endtask

  task automatic type_code(input int n, input bit exact);
    int d;
    for (int i = 0; i < n; i++) begin
      d = (exact && i < 4) ? int'(code_now[i*DIGIT_W +: DIGIT_W]) : $urandom_range(0, 9);
      press(digit_scan(d));
    end
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [FAIL_W-1:0] value);
    fail_limit_i = value;
    fail_limit_we_i = 1'b1;
    @(negedge clk_i);
    fail_limit_we_i = 1'b0;
    settings_used++;
  endtask

  task automatic settle_idle();
    for (int tries = 0; tries < 8 && mode_now != MODE_IDLE; tries++) begin
      send_key(SCAN_NONE);
      case (mode_now)
        MODE_UNLOCK: begin
          if (held_now == 0) press(SCAN_1);
          press(SCAN_STAR);
        end
        MODE_CHECK: begin
          if (held_now != 0) press(SCAN_HASH);
          type_code(4, 1'b1);
          press(SCAN_HASH);
        end
        MODE_NEWPW: begin
          if (held_now == 0) type_code($urandom_range(1, 4), 1'b0);
          press(SCAN_HASH);
        end
        default: ;
      endcase
    end
  endtask

  task automatic try_unlock(input bit exact);
    int n;
    press(SCAN_STAR);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    type_code(n, exact);
    press(SCAN_STAR);
  endtask

  task automatic change_code();
    press(SCAN_HASH);
    type_code($urandom_range(1, 4), $urandom_range(0, 3) != 0);
    press(SCAN_HASH);
    if (mode_now == MODE_NEWPW) begin
      type_code($urandom_range(1, 4), 1'b0);
      press(SCAN_HASH);
    end
  endtask

  task automatic misuse_keys();
    press(SCAN_STAR);
    press(SCAN_HASH);
    type_code(2, 1'b0);
    press(SCAN_HASH);
    send_key(SCAN_STAR);
    send_key(SCAN_STAR);
    send_key(SCAN_NONE);
  endtask

  task automatic key_noise();
    repeat ($urandom_range(2, 8)) send_key(KEY_W'($urandom_range(0, 31)));
    send_key(SCAN_NONE);
  endtask

  initial begin : result_taker
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_stall_i = 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_long = 1'b0;
      end
      n = draw_wait(take_style);
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] opening [25];
    int phase_len [5];
    int target;
    int pick;
    int unlock_share;
    bit long_done;
    bit pause_done;
    rst_ni = 1'b0;
    fail_limit_we_i = 1'b0;
    fail_limit_i = '0;
    in_valid_i = 1'b0;
    key_code_i = SCAN_NONE;
    keys_sent = 0;
    send_style = 1;
    take_style = 1;
    settings_used = 1;
    hold_long = 1'b0;
    long_done = 1'b0;
    pause_done = 1'b0;
    opening = '{SCAN_NONE, 5'd31, SCAN_1, SCAN_STAR, SCAN_STAR, SCAN_HASH, SCAN_STAR,
                SCAN_1, SCAN_HASH, SCAN_1, SCAN_STAR, SCAN_HASH, SCAN_0, SCAN_HASH,
                SCAN_1, SCAN_HASH, SCAN_STAR, SCAN_9, SCAN_8, SCAN_7, SCAN_6, SCAN_5,
                SCAN_0, SCAN_HASH, SCAN_NONE};
    phase_len = '{250, 250, 400, 275, 275};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (opening[i]) send_key(opening[i]);

    target = keys_sent;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin drain_results(); write_limit('0); end
        2: begin drain_results(); write_limit('1); end
        3: begin drain_results(); write_limit(FAIL_W'($urandom_range(1, 14))); end
        4: begin drain_results(); write_limit(FAIL_W'($urandom_range(0, 15))); end
        default: ;
      endcase
      target += phase_len[phase];
      unlock_share = (phase == 2) ? 70 : 55;
      while (keys_sent < target) begin
        if ($urandom_range(0, 15) == 0) begin
          send_style = $urandom_range(0, 2);
          take_style = $urandom_range(0, 2);
        end
        if (phase == 2 && !long_done && keys_sent > target - 200) begin
          hold_long = 1'b1;
          long_done = 1'b1;
        end
        if (phase == 3 && !pause_done && keys_sent > target - 140) begin
          drain_results();
          pause_done = 1'b1;
        end
        settle_idle();
        pick = $urandom_range(0, 99);
        if (pick < unlock_share) begin
          try_unlock((phase == 2) ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 1) == 1));
        end else if (pick < 85) begin
          change_code();
        end else if (pick < 93) begin
          key_noise();
        end else begin
          misuse_keys();
        end
      end
    end

    drain_results();
    $display("Run covered %0d key items and %0d checked results under %0d lockout limits.",
             keys_sent, checked, settings_used);
    $display("Event kinds observed, one bit per kind from none upward: %b", events_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
